@@ hdl/tdsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsd_pkg
// Shared types, constants and segment tables of the timer display driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdsd_pkg;

  localparam int unsigned TickW = 16;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd1;
  localparam logic [1:0] MODE_TIME = 2'd2;

  localparam logic CFG_ICON_STEP  = 1'b0;
  localparam logic CFG_BLINK_HALF = 1'b1;

  localparam logic [TickW-1:0] ICON_STEP_RST  = 16'd8;
  localparam logic [TickW-1:0] BLINK_HALF_RST = 16'd50;

  localparam logic [15:0] HOUR_SECS  = 16'd3600;
  localparam logic [15:0] RUN_OFFSET = 16'd59;
  // ceil(2^22 / 60), exact quotient for values below 3600
  localparam logic [16:0] RECIP_60   = 17'd69906;

  localparam logic [7:0] HEAT_MID   = 8'h80;
  localparam logic [7:0] HEAT_SIDE  = 8'h60;
  localparam logic [7:0] HEAT_BAR   = 8'h18;
  localparam logic [7:0] MARK_BIT   = 8'h08;
  localparam logic [7:0] DASH_HI    = 8'h10;

  // display request passed from the state stage to the decode stage
  typedef struct packed {
    logic        running;
    logic        heat_high;
    logic [1:0]  mode;
    logic        temp_hidden;
    logic        time_hidden;
    logic [1:0]  icon_phase;
    logic        colon_off;
    logic        dashes;
    logic        hour_fmt;
    logic [3:0]  hours;
    logic [11:0] rest;
  } tdsd_disp_t;

  function automatic logic [7:0] digit_hi(input logic [3:0] v);
    logic [7:0] r;
    case (v)
      4'd0:    r = 8'hE0;
      4'd1:    r = 8'hC0;
      4'd2:    r = 8'h70;
      4'd3:    r = 8'hF0;
      4'd4:    r = 8'hD0;
      4'd5:    r = 8'hB0;
      4'd6:    r = 8'hB0;
      4'd7:    r = 8'hE0;
      4'd8:    r = 8'hF0;
      4'd9:    r = 8'hF0;
      default: r = DASH_HI;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_lo(input logic [3:0] v);
    logic [7:0] r;
    case (v)
      4'd0:    r = 8'h07;
      4'd1:    r = 8'h00;
      4'd2:    r = 8'h03;
      4'd3:    r = 8'h01;
      4'd4:    r = 8'h04;
      4'd5:    r = 8'h05;
      4'd6:    r = 8'h07;
      4'd7:    r = 8'h00;
      4'd8:    r = 8'h07;
      4'd9:    r = 8'h05;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tdsd_state.sv @@
// ----------------------------------------------------------------------------
// tdsd_state
// Blink machine, icon and colon timers, and the split of the shown time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdsd_state import tdsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [TickW-1:0] cfg_data_i,
  input  logic             running_i,
  input  logic             key_active_i,
  input  logic             heat_high_i,
  input  logic [14:0]      set_seconds_i,
  input  logic [14:0]      remain_seconds_i,
  input  logic             mode_load_i,
  input  logic [1:0]       mode_value_i,
  input  logic             blink_load_i,
  input  logic [7:0]       blink_halves_i,
  output tdsd_disp_t       disp_o
);

  logic [TickW-1:0] icon_step_q, blink_half_q;
  logic [1:0]       mode_q, mode_d, mode_a;
  logic [7:0]       left_q, left_d, left_a;
  logic [TickW-1:0] btimer_q, btimer_d, btimer_inc;
  logic             th_q, th_d, tm_q, tm_d;
  logic [TickW-1:0] itimer_q, itimer_d, itimer_inc;
  logic [1:0]       phase_q, phase_d;
  logic [TickW-1:0] ctimer_q, ctimer_d, ctimer_inc;
  logic             coff_q, coff_d;
  logic [15:0]      shown;
  logic [8:0]       over;
  logic [3:0]       hours;
  logic [15:0]      hour_base;
  logic [15:0]      rest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icon_step_q  <= ICON_STEP_RST;
      blink_half_q <= BLINK_HALF_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ICON_STEP) begin
        icon_step_q <= cfg_data_i;
      end else begin
        blink_half_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    btimer_inc = (btimer_q == '1) ? btimer_q : btimer_q + 1'b1;
    itimer_inc = (itimer_q == '1) ? itimer_q : itimer_q + 1'b1;
    ctimer_inc = (ctimer_q == '1) ? ctimer_q : ctimer_q + 1'b1;
    mode_a     = mode_load_i ? mode_value_i : mode_q;
    left_a     = blink_load_i ? blink_halves_i : left_q;
    mode_d     = mode_a;
    left_d     = left_a;
    btimer_d   = btimer_q;
    th_d       = th_q;
    tm_d       = tm_q;

    // blink machine
    if (mode_a == MODE_NONE) begin
      th_d   = 1'b0;
      tm_d   = 1'b0;
      left_d = '0;
    end else if (left_a != '0 && !key_active_i) begin
      btimer_d = btimer_inc;
      if (btimer_inc >= blink_half_q) begin
        left_d   = left_a - 1'b1;
        btimer_d = '0;
        if (mode_a == MODE_TEMP) begin
          th_d = ~th_q;
          tm_d = 1'b0;
        end else if (mode_a == MODE_TIME) begin
          th_d = 1'b0;
          tm_d = ~tm_q;
        end
        if (left_d == '0) begin
          mode_d = MODE_NONE;
        end
      end
    end else begin
      th_d     = 1'b0;
      tm_d     = 1'b0;
      btimer_d = '0;
    end

    // icon and colon animation
    itimer_d = itimer_q;
    ctimer_d = ctimer_q;
    phase_d  = phase_q;
    coff_d   = coff_q;
    if (running_i) begin
      itimer_d = itimer_inc;
      if (itimer_inc >= icon_step_q) begin
        phase_d  = (phase_q >= 2'd2) ? 2'd0 : phase_q + 1'b1;
        itimer_d = '0;
      end
      ctimer_d = ctimer_inc;
      if (ctimer_inc >= blink_half_q) begin
        coff_d   = (remain_seconds_i != '0) ? ~coff_q : 1'b0;
        ctimer_d = '0;
      end
    end else begin
      phase_d = 2'd0;
      coff_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      left_q   <= '0;
      btimer_q <= '0;
      th_q     <= 1'b0;
      tm_q     <= 1'b0;
      itimer_q <= '0;
      phase_q  <= 2'd0;
      ctimer_q <= '0;
      coff_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      left_q   <= left_d;
      btimer_q <= btimer_d;
      th_q     <= th_d;
      tm_q     <= tm_d;
      itimer_q <= itimer_d;
      phase_q  <= phase_d;
      ctimer_q <= ctimer_d;
      coff_q   <= coff_d;
    end
  end

  // shown time split into hours and the remainder below one hour
  always_comb begin
    shown = (running_i && mode_d != MODE_TIME) ?
            {1'b0, remain_seconds_i} + RUN_OFFSET : {1'b0, set_seconds_i};
    for (int k = 0; k < 9; k++) begin
      over[k] = shown >= HOUR_SECS * 16'(k + 1);
    end
    hours     = 4'($countones(over));
    hour_base = HOUR_SECS * 16'(hours);
    rest      = shown - hour_base;
  end

  always_comb begin
    disp_o.running     = running_i;
    disp_o.heat_high   = heat_high_i;
    disp_o.mode        = mode_d;
    disp_o.temp_hidden = th_d;
    disp_o.time_hidden = tm_d;
    disp_o.icon_phase  = phase_d;
    disp_o.colon_off   = coff_d;
    disp_o.dashes      = (set_seconds_i == '0) || (shown == '0);
    disp_o.hour_fmt    = hours != '0;
    disp_o.hours       = hours;
    disp_o.rest        = rest[11:0];
  end

endmodule

@@ hdl/tdsd_decode.sv @@
// ----------------------------------------------------------------------------
// tdsd_decode
// Builds the heat icon, the marks and the four seven-segment time digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdsd_decode import tdsd_pkg::*; (
  input  tdsd_disp_t disp_i,
  output logic [7:0] seg_o [10]
);

  logic [28:0] prod60;
  logic [5:0]  minutes, seconds;
  logic [5:0]  pair_a, pair_b;
  logic [13:0] prod_a, prod_b;
  logic [2:0]  tens_a, tens_b;
  logic [3:0]  dig [4];
  logic        colon_on;

  always_comb begin
    prod60  = {17'd0, disp_i.rest} * {12'd0, RECIP_60};
    minutes = prod60[27:22];
    seconds = 6'(disp_i.rest - 12'(minutes) * 12'd60);
    pair_a  = disp_i.hour_fmt ? {2'd0, disp_i.hours} : minutes;
    pair_b  = disp_i.hour_fmt ? minutes : seconds;
    prod_a  = 14'(pair_a) * 14'd205;
    prod_b  = 14'(pair_b) * 14'd205;
    tens_a  = prod_a[13:11];
    tens_b  = prod_b[13:11];
    dig[0]  = {1'b0, tens_a};
    dig[1]  = 4'(pair_a - 6'(tens_a) * 6'd10);
    dig[2]  = {1'b0, tens_b};
    dig[3]  = 4'(pair_b - 6'(tens_b) * 6'd10);
    if (disp_i.dashes) begin
      for (int i = 0; i < 4; i++) begin
        dig[i] = 4'd10;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      seg_o[i] = '0;
    end

    // heat icon
    if (disp_i.running && disp_i.mode != MODE_TEMP) begin
      case (disp_i.icon_phase)
        2'd0: begin
          seg_o[0] = HEAT_BAR | (disp_i.heat_high ? 8'h40 : 8'h00);
          seg_o[1] = 8'h01 | (disp_i.heat_high ? 8'h04 : 8'h00);
        end
        2'd1: begin
          seg_o[0] = HEAT_MID | HEAT_BAR | (disp_i.heat_high ? 8'h20 : 8'h00);
          seg_o[1] = disp_i.heat_high ? 8'h02 : 8'h00;
        end
        default: begin
          seg_o[0] = HEAT_MID | HEAT_BAR | (disp_i.heat_high ? HEAT_SIDE : 8'h00);
          seg_o[1] = 8'h01 | (disp_i.heat_high ? 8'h06 : 8'h00);
        end
      endcase
    end else if (!disp_i.temp_hidden) begin
      seg_o[0] = HEAT_MID | HEAT_BAR | (disp_i.heat_high ? HEAT_SIDE : 8'h00);
      seg_o[1] = 8'h01 | (disp_i.heat_high ? 8'h06 : 8'h00);
    end

    // colon and minute marks
    colon_on = !disp_i.running || disp_i.mode == MODE_TIME || !disp_i.colon_off;
    if (colon_on) begin
      seg_o[2] = MARK_BIT;
      seg_o[4] = MARK_BIT;
    end
    seg_o[6] = MARK_BIT;
    seg_o[8] = MARK_BIT;

    // time digits
    if (!disp_i.time_hidden) begin
      for (int i = 0; i < 4; i++) begin
        seg_o[2 + 2 * i] = seg_o[2 + 2 * i] | digit_hi(dig[i]);
        seg_o[3 + 2 * i] = digit_lo(dig[i]);
      end
    end
  end

endmodule

@@ hdl/timer_display_segment_driver_unit.sv @@
// ----------------------------------------------------------------------------
// timer_display_segment_driver_unit
// LED segment driver for an appliance timer display with blink and animation.
// ----------------------------------------------------------------------------
// One request on the input channel is one display tick. It carries the run
// and key flags, the heat level, the set and remaining times and optional
// loads of the setting mode and the blink count. Each request gives exactly
// one result: ten segment bytes and the setting mode after the tick.
// Both channels use valid/ready. The configuration port writes the icon step
// and the blink half period, both counted in ticks.
// The blink, icon and colon state updates and the hour split of the shown
// time happen in the cycle of acceptance; the digit and segment decode sits
// between the stage register and the output register. One request per cycle
// is taken while the receiver keeps up; with the stage register empty, one
// is taken while the previous result still waits in the output register.
// When the receiver stalls, the output register holds its result, the stage
// register holds the next one, and then input ready drops.
// Reset clears all timers, flags and the setting mode and loads the register
// defaults (icon step 8, blink half period 50); no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_display_segment_driver_unit import tdsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [TickW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             running_i,
  input  logic             key_active_i,
  input  logic             heat_high_i,
  input  logic [14:0]      set_seconds_i,
  input  logic [14:0]      remain_seconds_i,
  input  logic             mode_load_i,
  input  logic [1:0]       mode_value_i,
  input  logic             blink_load_i,
  input  logic [7:0]       blink_halves_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       seg_byte0_o,
  output logic [7:0]       seg_byte1_o,
  output logic [7:0]       seg_byte2_o,
  output logic [7:0]       seg_byte3_o,
  output logic [7:0]       seg_byte4_o,
  output logic [7:0]       seg_byte5_o,
  output logic [7:0]       seg_byte6_o,
  output logic [7:0]       seg_byte7_o,
  output logic [7:0]       seg_byte8_o,
  output logic [7:0]       seg_byte9_o,
  output logic [1:0]       mode_now_o
);

  logic       accept, out_move;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  tdsd_disp_t disp_d, disp_q;
  logic [7:0] seg_d [10];
  logic [7:0] seg_q [10];
  logic [1:0] mode_q;

  assign out_move   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_move;
  assign accept     = in_valid_i && in_ready_o;

  tdsd_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .running_i        (running_i),
    .key_active_i     (key_active_i),
    .heat_high_i      (heat_high_i),
    .set_seconds_i    (set_seconds_i),
    .remain_seconds_i (remain_seconds_i),
    .mode_load_i      (mode_load_i),
    .mode_value_i     (mode_value_i),
    .blink_load_i     (blink_load_i),
    .blink_halves_i   (blink_halves_i),
    .disp_o           (disp_d)
  );

  tdsd_decode u_decode (
    .disp_i (disp_q),
    .seg_o  (seg_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      disp_q <= disp_d;
    end
    if (out_move) begin
      seg_q  <= seg_d;
      mode_q <= disp_q.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_byte0_o = seg_q[0];
  assign seg_byte1_o = seg_q[1];
  assign seg_byte2_o = seg_q[2];
  assign seg_byte3_o = seg_q[3];
  assign seg_byte4_o = seg_q[4];
  assign seg_byte5_o = seg_q[5];
  assign seg_byte6_o = seg_q[6];
  assign seg_byte7_o = seg_q[7];
  assign seg_byte8_o = seg_q[8];
  assign seg_byte9_o = seg_q[9];
  assign mode_now_o  = mode_q;

endmodule

@@ hdl/tdsd_checker.sv @@
// ----------------------------------------------------------------------------
// tdsd_checker
// Port-level checks of the timer display driver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] seg_byte0_o,
  input logic [7:0] seg_byte1_o,
  input logic [7:0] seg_byte3_o,
  input logic [7:0] seg_byte5_o,
  input logic [7:0] seg_byte6_o,
  input logic [7:0] seg_byte7_o,
  input logic [7:0] seg_byte8_o,
  input logic [7:0] seg_byte9_o,
  input logic [1:0] mode_now_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(seg_byte0_o)
      && $stable(seg_byte9_o) && $stable(mode_now_o))
    else $error("stalled result changed");

  // result follows an accepted request when the receiver is ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("result missing two cycles after request");

  // unused segment bits stay low
  a_unused_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seg_byte0_o[2:0] == 3'd0 && seg_byte1_o[7:3] == 5'd0
      && seg_byte3_o[7:3] == 5'd0 && seg_byte5_o[7:3] == 5'd0
      && seg_byte7_o[7:3] == 5'd0 && seg_byte9_o[7:3] == 5'd0)
    else $error("unused segment bit set");

  // minute marks always lit
  a_minute_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seg_byte6_o[3] && seg_byte8_o[3])
    else $error("minute mark dark");

endmodule

bind timer_display_segment_driver_unit tdsd_checker u_tdsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .seg_byte0_o (seg_byte0_o),
  .seg_byte1_o (seg_byte1_o),
  .seg_byte3_o (seg_byte3_o),
  .seg_byte5_o (seg_byte5_o),
  .seg_byte6_o (seg_byte6_o),
  .seg_byte7_o (seg_byte7_o),
  .seg_byte8_o (seg_byte8_o),
  .seg_byte9_o (seg_byte9_o),
  .mode_now_o  (mode_now_o)
);
